FILE: hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

FILE: hdl/smma_pkg.sv
package smma_pkg;
    localparam int CELL_BITS = 64;
    localparam int CW = 64;
    localparam logic [3:0] OP_DIV = 4'd0, OP_MOD = 4'd1, OP_QUOT_REM = 4'd2,
        OP_MULDIV = 4'd3, OP_SHL = 4'd4, OP_SHR = 4'd5, OP_GT = 4'd6,
        OP_LE = 4'd7, OP_GE = 4'd8, OP_NE = 4'd9, OP_OR = 4'd10, OP_AND = 4'd11,
        OP_MIN = 4'd12, OP_MAX = 4'd13, OP_ABS = 4'd14, OP_NONE = 4'd15;
    // low cell bits sign-extended to 64
    function automatic logic [CW-1:0] cellx(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        r = v;
        for (int i = CELL_BITS; i < CW; i++) r[i] = v[CELL_BITS-1];
        return r;
    endfunction
    typedef struct packed {
        logic [3:0]    op;
        logic          neg_q;
        logic          neg_r;
        logic          dz;
        logic          direct;
        logic [CW-1:0] dvd;
        logic [CW-1:0] dvs;
        logic [CW-1:0] sdvs;
        logic [CW-1:0] v1;
    } smma_ctl_t;
endpackage

FILE: hdl/smma_divider.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module smma_divider (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  smma_pkg::smma_ctl_t      in_ctl,
    output logic                     out_valid,
    output smma_pkg::smma_ctl_t      out_ctl,
    output logic [smma_pkg::CW-1:0]  out_rem
);
    import smma_pkg::*;
    logic [CW-1:0]       valid_reg;
    smma_ctl_t           ctl_reg   [0:CW-1];
    logic [CW-1:0]       rem_reg   [0:CW-1];
    smma_ctl_t           ctl_next  [0:CW-1];
    logic [CW-1:0]       rem_next  [0:CW-1];

    function automatic void div_step(input smma_ctl_t c, input logic [CW-1:0] r,
                                     output smma_ctl_t c_o, output logic [CW-1:0] r_o);
        logic [CW:0] trial;
        c_o = c;
        trial = {r, c.dvd[CW-1]} - {1'b0, c.dvs};
        if (!trial[CW]) begin
            r_o = trial[CW-1:0];
            c_o.dvd = {c.dvd[CW-2:0], 1'b1};
        end else begin
            r_o = {r[CW-2:0], c.dvd[CW-1]};
            c_o.dvd = {c.dvd[CW-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        div_step(in_ctl, '0, ctl_next[0], rem_next[0]);
        for (int i = 1; i < CW; i++) begin
            div_step(ctl_reg[i-1], rem_reg[i-1], ctl_next[i], rem_next[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= '0;
        else if (en) valid_reg <= {valid_reg[CW-2:0], in_valid};
        if (en) begin
            for (int i = 0; i < CW; i++) begin
                ctl_reg[i] <= ctl_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end
    assign out_valid = valid_reg[CW-1];
    assign out_ctl   = ctl_reg[CW-1];
    assign out_rem   = rem_reg[CW-1];
endmodule

FILE: hdl/stack_machine_math_alu.sv
// Channel | Handshake         | Payload
// s_      | s_valid/s_ready   | operation, top, second, third operand
// m_      | m_valid/m_ready   | first/second value, push/pop count, divide_by_zero
// Pipeline registers, in order: partial products, product sum, operand prep, 64 divider stages, fixup.
// One transaction per cycle sustained while the output is not stalled; every op flows through the same pipe.
// Synchronous active-low reset clears valid bits only.
// m_valid && !m_ready freezes the whole pipe; s_ready = !m_valid || m_ready.
module stack_machine_math_alu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic signed [63:0] s_top_operand,
    input  logic signed [63:0] s_second_operand,
    input  logic signed [63:0] s_third_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [63:0] m_first_value,
    output logic signed [63:0] m_second_value,
    output logic [1:0]  m_push_count,
    output logic [1:0]  m_pop_count,
    output logic        m_divide_by_zero
);
    import smma_pkg::*;
    `include "assert_macros.svh"

    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: 32x32 partial products of the low product half
    logic          pv_reg;
    logic [3:0]    op0_reg;
    logic [CW-1:0] t0_reg, s0_reg, pll_reg;
    logic [31:0]   phx_reg, phy_reg;
    logic [CW-1:0] u_in, sv_in;
    assign u_in  = cellx(s_third_operand);
    assign sv_in = cellx(s_second_operand);
    always_ff @(posedge aclk) begin
        if (!aresetn) pv_reg <= 1'b0;
        else if (en) pv_reg <= s_valid;
        if (en) begin
            op0_reg <= s_operation;
            t0_reg  <= cellx(s_top_operand);
            s0_reg  <= sv_in;
            pll_reg <= CW'(u_in[31:0]) * CW'(sv_in[31:0]);
            phx_reg <= u_in[CW-1:32] * sv_in[31:0];
            phy_reg <= u_in[31:0] * sv_in[CW-1:32];
        end
    end

    // stage 2: product sum, wrapped to the cell
    logic          v1_reg;
    logic [3:0]    op1_reg;
    logic [CW-1:0] t1_reg, s1_reg, p1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= pv_reg;
        if (en) begin
            op1_reg <= op0_reg;
            t1_reg  <= t0_reg;
            s1_reg  <= s0_reg;
            p1_reg  <= cellx(pll_reg + {phx_reg + phy_reg, 32'd0});
        end
    end

    // stage 3: non-division results, divider operand prep
    smma_ctl_t ctl_next, ctl_reg;
    logic      v2_reg;
    always_comb begin
        logic [CW-1:0] a, b, sh;
        logic lt_ts, lt_st;
        logic [5:0] n;
        a = (op1_reg == OP_MULDIV) ? p1_reg : s1_reg;
        b = t1_reg;
        lt_ts = $signed(t1_reg) < $signed(s1_reg);
        lt_st = $signed(s1_reg) < $signed(t1_reg);
        n = (t1_reg >= CW'(CELL_BITS)) ? 6'(CELL_BITS - 1) : t1_reg[5:0];
        sh = CW'($signed(s1_reg) >>> n);
        ctl_next = '0;
        ctl_next.op = op1_reg;
        ctl_next.direct = 1'b1;
        ctl_next.dvs = '1;
        case (op1_reg)
            OP_DIV, OP_MOD, OP_QUOT_REM, OP_MULDIV: begin
                if (b == '0) ctl_next.dz = 1'b1;
                else begin
                    ctl_next.direct = 1'b0;
                    ctl_next.dvd = a[CW-1] ? -a : a;
                    ctl_next.dvs = b[CW-1] ? -b : b;
                    ctl_next.sdvs = b;
                    ctl_next.neg_q = a[CW-1] ^ b[CW-1];
                    ctl_next.neg_r = a[CW-1];
                end
            end
            OP_SHL: ctl_next.v1 = (t1_reg >= CW'(CELL_BITS)) ? '0
                                  : cellx(s1_reg << t1_reg[5:0]);
            OP_SHR: ctl_next.v1 = sh;
            OP_GT:  ctl_next.v1 = CW'(lt_ts);
            OP_LE:  ctl_next.v1 = CW'(!lt_ts);
            OP_GE:  ctl_next.v1 = CW'(!lt_st);
            OP_NE:  ctl_next.v1 = CW'(s1_reg != t1_reg);
            OP_OR:  ctl_next.v1 = CW'(s1_reg != '0 || t1_reg != '0);
            OP_AND: ctl_next.v1 = CW'(s1_reg != '0 && t1_reg != '0);
            OP_MIN: ctl_next.v1 = lt_ts ? t1_reg : s1_reg;
            OP_MAX: ctl_next.v1 = lt_st ? t1_reg : s1_reg;
            OP_ABS: ctl_next.v1 = t1_reg[CW-1] ? cellx(-t1_reg) : t1_reg;
            default: ctl_next.v1 = t1_reg;
        endcase
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) ctl_reg <= ctl_next;
    end

    logic          dv_valid;
    smma_ctl_t     dv_ctl;
    logic [CW-1:0] dv_rem;
    smma_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .in_ctl(ctl_reg), .out_valid(dv_valid), .out_ctl(dv_ctl), .out_rem(dv_rem)
    );

    // output stage: sign fixup
    logic          ov_reg;
    logic [CW-1:0] f_reg, s_reg;
    logic [1:0]    pu_reg, po_reg;
    logic          dz_reg;
    logic [CW-1:0] f_reg_next, s_reg_next;
    always_comb begin
        logic [CW-1:0] q, r, mag, addend;
        logic fix;
        q = dv_ctl.neg_q ? -dv_ctl.dvd : dv_ctl.dvd;
        // floored modulo in one adder: +-rem, plus the divisor when rem is nonzero and signs differ
        fix = (dv_rem != '0) && (dv_ctl.neg_r != dv_ctl.sdvs[CW-1]);
        mag = dv_ctl.neg_r ? ~dv_rem : dv_rem;
        addend = fix ? dv_ctl.sdvs : '0;
        r = mag + addend + CW'(dv_ctl.neg_r);
        q = cellx(q);
        r = cellx(r);
        f_reg_next = dv_ctl.v1;
        s_reg_next = '0;
        if (!dv_ctl.direct) begin
            f_reg_next = (dv_ctl.op == OP_MOD) ? r : q;
            if (dv_ctl.op == OP_QUOT_REM) s_reg_next = r;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (en) ov_reg <= dv_valid;
        if (en) begin
            f_reg  <= f_reg_next;
            s_reg  <= s_reg_next;
            dz_reg <= dv_ctl.dz;
            pu_reg <= (dv_ctl.op == OP_QUOT_REM) ? 2'd2 : 2'd1;
            po_reg <= (dv_ctl.op == OP_MULDIV) ? 2'd3 :
                      (dv_ctl.op == OP_ABS || dv_ctl.op == OP_NONE) ? 2'd1 : 2'd2;
        end
    end
    assign m_valid = ov_reg;
    assign m_first_value = f_reg;
    assign m_second_value = s_reg;
    assign m_push_count = pu_reg;
    assign m_pop_count = po_reg;
    assign m_divide_by_zero = dz_reg;

    `ASSERT_IMPL(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_first_value))
    `ASSERT_NEVER(a_dz_zero, aclk, aresetn, m_valid && m_divide_by_zero && m_first_value != '0)
    `ASSERT_NEVER(a_push2, aclk, aresetn, m_valid && m_push_count == 2'd2 && m_pop_count != 2'd2)
endmodule

FILE: tb/sv/stack_machine_math_alu_tb.sv
module stack_machine_math_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smma_pkg::*;

    localparam logic [63:0] MIN_CELL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_CELL = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [63:0] first_value;
        logic [63:0] second_value;
        logic [1:0]  push_count;
        logic [1:0]  pop_count;
        logic        divide_by_zero;
    } alu_result_t;

    typedef struct {
        logic [3:0]  op;
        logic [63:0] top;
        logic [63:0] second;
        logic [63:0] third;
        bit          typed;
        alu_result_t res;
    } stim_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [3:0] s_operation = '0;
    logic signed [63:0] s_top_operand = '0;
    logic signed [63:0] s_second_operand = '0;
    logic signed [63:0] s_third_operand = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [63:0] m_first_value;
    logic signed [63:0] m_second_value;
    logic [1:0] m_push_count;
    logic [1:0] m_pop_count;
    logic m_divide_by_zero;

    alu_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    bit quiet_phase = 0;

    stack_machine_math_alu uut (.*);

    always #5 aclk = ~aclk;

    // truncating quotient, floored modulo; divisor nonzero
    function automatic void div_floor(input logic [63:0] a, input logic [63:0] b,
                                      output logic [63:0] q, output logic [63:0] r);
        logic signed [63:0] sa, sb, sq, sr;
        sa = a;
        sb = b;
        if (b == ALL_ONES) begin
            q = 64'd0 - a;
            r = 0;
            return;
        end
        sq = sa / sb;
        sr = sa % sb;
        if (sr != 0 && ((sr < 0) != (sb < 0))) sr = sr + sb;
        q = sq;
        r = sr;
    endfunction

    function automatic alu_result_t alu_predict(input logic [3:0] op, input logic [63:0] t,
                                                input logic [63:0] s, input logic [63:0] u);
        alu_result_t e;
        logic [63:0] q, r, dvd;
        logic signed [63:0] st, ss;
        e = '0;
        e.push_count = 2'd1;
        e.pop_count = 2'd2;
        st = t;
        ss = s;
        case (op)
            OP_DIV, OP_MOD, OP_QUOT_REM, OP_MULDIV: begin
                dvd = s;
                if (op == OP_MULDIV) begin
                    e.pop_count = 2'd3;
                    dvd = u * s;
                end
                if (op == OP_QUOT_REM) e.push_count = 2'd2;
                if (t == 0) begin
                    e.divide_by_zero = 1'b1;
                end else begin
                    div_floor(dvd, t, q, r);
                    if (op == OP_MOD) e.first_value = r;
                    else e.first_value = q;
                    if (op == OP_QUOT_REM) e.second_value = r;
                end
            end
            OP_SHL: e.first_value = (t >= 64) ? 64'd0 : s << t[5:0];
            OP_SHR: e.first_value = ss >>> ((t >= 64) ? 6'd63 : t[5:0]);
            OP_GT:  e.first_value = 64'(st < ss);
            OP_LE:  e.first_value = 64'(!(st < ss));
            OP_GE:  e.first_value = 64'(!(ss < st));
            OP_NE:  e.first_value = 64'(s != t);
            OP_OR:  e.first_value = 64'(s != 0 || t != 0);
            OP_AND: e.first_value = 64'(s != 0 && t != 0);
            OP_MIN: e.first_value = (st < ss) ? t : s;
            OP_MAX: e.first_value = (ss < st) ? t : s;
            OP_ABS: begin
                e.pop_count = 2'd1;
                e.first_value = t[63] ? 64'd0 - t : t;
            end
            default: begin
                e.pop_count = 2'd1;
                e.first_value = t;
            end
        endcase
        return e;
    endfunction

    function automatic alu_result_t typed_res(input logic [63:0] v1, input logic [63:0] v2,
                                              input logic [1:0] push, input logic [1:0] pop,
                                              input logic dz);
        alu_result_t e;
        e.first_value = v1;
        e.second_value = v2;
        e.push_count = push;
        e.pop_count = pop;
        e.divide_by_zero = dz;
        return e;
    endfunction

    function automatic logic [63:0] rand_cell();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = MIN_CELL;
            1: v = MAX_CELL;
            2: v = ALL_ONES;
            3: v = 0;
            4: v = 64'($urandom_range(0, 70));
            5: v = -$signed(64'($urandom_range(0, 70)));
            6: v = {{32{v[31]}}, v[31:0]};
            default: ;
        endcase
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(input logic [3:0] op, input logic [63:0] t,
                        input logic [63:0] s, input logic [63:0] u,
                        input bit typed, input alu_result_t res);
        while (!quiet_phase && $urandom_range(0, 99) < 29) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_operation <= op;
        s_top_operand <= t;
        s_second_operand <= s;
        s_third_operand <= u;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(typed ? res : alu_predict(op, t, s, u));
        @(negedge aclk);
    endtask

    // result side: ready toggles at falling edges
    always @(negedge aclk) begin
        if (aresetn) m_ready <= quiet_phase || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge aclk) begin
        alu_result_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stack_machine_math_alu_tb: errors");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_first_value !== e.first_value) begin
                    $error("first_value exp %h got %h", e.first_value, m_first_value);
                    errors++;
                end
                if (m_second_value !== e.second_value) begin
                    $error("second_value exp %h got %h", e.second_value, m_second_value);
                    errors++;
                end
                if (m_push_count !== e.push_count) begin
                    $error("push_count exp %0d got %0d", e.push_count, m_push_count);
                    errors++;
                end
                if (m_pop_count !== e.pop_count) begin
                    $error("pop_count exp %0d got %0d", e.pop_count, m_pop_count);
                    errors++;
                end
                if (m_divide_by_zero !== e.divide_by_zero) begin
                    $error("divide_by_zero exp %0d got %0d", e.divide_by_zero,
                           m_divide_by_zero);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        logic [3:0] op;
        logic [63:0] t;
        alu_result_t none;
        int k;
        none = '0;
        rows = '{
            '{OP_DIV,      64'd0,    64'd5,    64'd0, 1, typed_res(0, 0, 1, 2, 1)},
            '{OP_MOD,      64'd0,    64'd5,    64'd0, 1, typed_res(0, 0, 1, 2, 1)},
            '{OP_QUOT_REM, 64'd0,    64'd5,    64'd0, 1, typed_res(0, 0, 2, 2, 1)},
            '{OP_MULDIV,   64'd0,    64'd5,    64'd3, 1, typed_res(0, 0, 1, 3, 1)},
            '{OP_DIV,      ALL_ONES, MIN_CELL, 64'd0, 1, typed_res(MIN_CELL, 0, 1, 2, 0)},
            '{OP_QUOT_REM, ALL_ONES, MIN_CELL, 64'd0, 1, typed_res(MIN_CELL, 0, 2, 2, 0)},
            '{OP_MOD,      -64'sd3,  64'd7,    64'd0, 0, none},
            '{OP_MOD,      64'd3,    -64'sd7,  64'd0, 0, none},
            '{OP_MOD,      -64'sd3,  -64'sd6,  64'd0, 1, typed_res(0, 0, 1, 2, 0)},
            '{OP_QUOT_REM, 64'd4,    -64'sd9,  64'd0, 0, none},
            '{OP_MULDIV,   64'd7,    MAX_CELL, MAX_CELL, 0, none},
            '{OP_SHL,      64'd64,   ALL_ONES, 64'd0, 1, typed_res(0, 0, 1, 2, 0)},
            '{OP_SHL,      64'd63,   64'd3,    64'd0, 1, typed_res(MIN_CELL, 0, 1, 2, 0)},
            '{OP_SHL,      ALL_ONES, 64'd1,    64'd0, 1, typed_res(0, 0, 1, 2, 0)},
            '{OP_SHR,      ALL_ONES, MIN_CELL, 64'd0, 1, typed_res(ALL_ONES, 0, 1, 2, 0)},
            '{OP_SHR,      64'd200,  MAX_CELL, 64'd0, 1, typed_res(0, 0, 1, 2, 0)},
            '{OP_GT,       MIN_CELL, MAX_CELL, 64'd0, 1, typed_res(1, 0, 1, 2, 0)},
            '{OP_LE,       MIN_CELL, MAX_CELL, 64'd0, 1, typed_res(0, 0, 1, 2, 0)},
            '{OP_GE,       64'd5,    64'd5,    64'd0, 1, typed_res(1, 0, 1, 2, 0)},
            '{OP_NE,       64'd5,    64'd5,    64'd0, 1, typed_res(0, 0, 1, 2, 0)},
            '{OP_OR,       64'd0,    64'd0,    64'd0, 1, typed_res(0, 0, 1, 2, 0)},
            '{OP_AND,      ALL_ONES, MIN_CELL, 64'd0, 1, typed_res(1, 0, 1, 2, 0)},
            '{OP_MIN,      MIN_CELL, MAX_CELL, 64'd0, 1, typed_res(MIN_CELL, 0, 1, 2, 0)},
            '{OP_MAX,      MIN_CELL, MAX_CELL, 64'd0, 1, typed_res(MAX_CELL, 0, 1, 2, 0)},
            '{OP_ABS,      MIN_CELL, 64'd0,    64'd0, 1, typed_res(MIN_CELL, 0, 1, 1, 0)},
            '{OP_NONE,     MAX_CELL, 64'd9,    64'd9, 1, typed_res(MAX_CELL, 0, 1, 1, 0)}
        };
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        foreach (rows[i]) begin
            row = rows[i];
            send(row.op, row.top, row.second, row.third, row.typed, row.res);
        end
        for (k = 0; k < 1450; k++) begin
            quiet_phase = (k >= 300 && k < 500);
            if (k == 700) begin
                // drain before resuming
                s_valid <= 0;
                @(negedge aclk);
                while (pending_results.size() != 0) @(negedge aclk);
            end
            op = 4'($urandom_range(0, 15));
            t = rand_cell();
            if (op <= OP_MULDIV && $urandom_range(0, 9) != 0 && t == 0) t = 1;
            send(op, t, rand_cell(), rand_cell(), 0, none);
        end
        s_valid <= 0;
        quiet_phase = 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) $display("stack_machine_math_alu_tb: clean");
        else $display("stack_machine_math_alu_tb: errors");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/smma_pkg.sv
hdl/smma_divider.sv
hdl/stack_machine_math_alu.sv
tb/sv/stack_machine_math_alu_tb.sv
